// ===== design/s2i_pkg.sv =====
// Package for the string-to-integer parser: phase codes, state and result
// structs, and the character classification helpers.
// No dependencies; every other design file imports it.
`default_nettype none

package s2i_pkg;

    // Default saturation point of the consumed-character count.
    localparam longint unsigned COUNT_MAX_DEF = 65535;

    // Field widths fixed by the stream format.
    localparam int unsigned BASE_W   = 6;
    localparam int unsigned CHAR_W   = 8;
    localparam int unsigned VALUE_W  = 64;
    localparam int unsigned OFFSET_W = 16;
    localparam int unsigned PROD_W   = VALUE_W + BASE_W;
    localparam int unsigned DIGIT_W  = 7;

    // Payload widths, padded up to whole bytes.
    localparam int unsigned S_TDATA_W = 16;
    localparam int unsigned M_TDATA_W = 88;

    // Character codes.
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_UP_A  = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UP_X  = 8'h58;
    localparam logic [CHAR_W-1:0] CH_UP_Z  = 8'h5A;
    localparam logic [CHAR_W-1:0] CH_LO_A  = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LO_X  = 8'h78;
    localparam logic [CHAR_W-1:0] CH_LO_Z  = 8'h7A;

    // Radix codes.
    localparam logic [BASE_W-1:0] RADIX_AUTO = 6'd0;
    localparam logic [BASE_W-1:0] RADIX_OCT  = 6'd8;
    localparam logic [BASE_W-1:0] RADIX_DEC  = 6'd10;
    localparam logic [BASE_W-1:0] RADIX_HEX  = 6'd16;

    // Digit value returned for a character that is not alphanumeric.
    localparam logic [DIGIT_W-1:0] NOT_DIGIT = 7'd64;

    // Most negative value of the signed result.
    localparam logic [VALUE_W-1:0] SMIN = {1'b1, {(VALUE_W-1){1'b0}}};

    // Conversion phases, one-hot.
    typedef enum logic [5:0] {
        PH_IDLE   = 6'b000001,
        PH_SPACE  = 6'b000010,
        PH_PREFIX = 6'b000100,
        PH_ZERO   = 6'b001000,
        PH_DIGITS = 6'b010000,
        PH_DONE   = 6'b100000
    } phase_t;

    // Conversion state carried from one item to the next.
    typedef struct packed {
        phase_t              phase;
        logic [BASE_W-1:0]   radix;
        logic                negative;
        logic [VALUE_W-1:0]  acc;
        logic                ovf;
    } state_t;

    // One result item.
    typedef struct packed {
        logic                ovf;
        logic [OFFSET_W-1:0] end_offset;
        logic [VALUE_W-1:0]  value;
    } result_t;

    // White space: space, TAB, LF, VT, FF, CR.
    function automatic logic is_space(input logic [CHAR_W-1:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    // Digit value 0..35, or NOT_DIGIT for any other character.
    function automatic logic [DIGIT_W-1:0] digit_of(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] v;
        v = CHAR_W'(NOT_DIGIT);
        if ((c >= CH_ZERO) && (c <= CH_NINE))
            v = c - CH_ZERO;
        else if ((c >= CH_LO_A) && (c <= CH_LO_Z))
            v = c - CH_LO_A + 8'd10;
        else if ((c >= CH_UP_A) && (c <= CH_UP_Z))
            v = c - CH_UP_A + 8'd10;
        return v[DIGIT_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== design/string_to_integer_parser.sv =====
// A result is registered from its terminating item as that item leaves the input register.
// Throughput: one item per cycle while the result slot is not stalled; the
// accumulator multiply-add is combinational, so a character can follow at once.
// Reset (rst_n low, asynchronous): both stages empty, conversion state idle.
// Depends on s2i_pkg and s2i_step.
`default_nettype none

module string_to_integer_parser #(
    parameter longint unsigned COUNT_MAX = s2i_pkg::COUNT_MAX_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // tdata: base_req [5:0], ch [13:6], zero pad [15:14]
    input  wire logic [s2i_pkg::S_TDATA_W-1:0]    s_tdata,
    // tuser: start_req [0]
    input  wire logic                             s_tuser,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // tdata: value [63:0], end_offset [79:64], overflow [80], zero pad [87:81]
    output logic [s2i_pkg::M_TDATA_W-1:0]         m_tdata
);
    import s2i_pkg::*;

    localparam int unsigned CNT_W = $clog2(COUNT_MAX + 1);

    logic                in_valid_reg;
    logic                in_start_reg;
    logic [BASE_W-1:0]   in_base_reg;
    logic [CHAR_W-1:0]   in_ch_reg;
    state_t              state_reg;
    state_t              state_next;
    logic [CNT_W-1:0]    cnt_reg;
    logic [CNT_W-1:0]    cnt_next;
    logic                out_valid_reg;
    result_t             out_res_reg;
    result_t             res_next;
    logic                emit;
    logic                advance;

    // The input register moves on when the result slot is free or draining.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_start_reg <= s_tuser;
            in_base_reg  <= s_tdata[BASE_W-1:0];
            in_ch_reg    <= s_tdata[BASE_W+CHAR_W-1:BASE_W];
        end
    end

    // Per-character update.
    s2i_step #(
        .COUNT_MAX (COUNT_MAX),
        .CNT_W     (CNT_W)
    ) u_step (
        .start_req (in_start_reg),
        .base_req  (in_base_reg),
        .ch        (in_ch_reg),
        .state_in  (state_reg),
        .cnt_in    (cnt_reg),
        .state_out (state_next),
        .cnt_out   (cnt_next),
        .emit      (emit),
        .result    (res_next)
    );

    // Conversion state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '{phase: PH_IDLE, radix: '0, negative: 1'b0, acc: '0, ovf: 1'b0};
            cnt_reg   <= '0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance && emit)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit)
            out_res_reg <= res_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_TDATA_W'(out_res_reg);

endmodule

`default_nettype wire

// ===== design/s2i_step.sv =====
// Per-character update of the parser: phase decode, multiply-add of the
// accumulator with overflow detection, and result formation.
// Depends on s2i_pkg.
`default_nettype none

module s2i_step #(
    parameter longint unsigned COUNT_MAX = s2i_pkg::COUNT_MAX_DEF,
    parameter int unsigned     CNT_W     = 16
) (
    input  wire logic                              start_req,
    input  wire logic [s2i_pkg::BASE_W-1:0]        base_req,
    input  wire logic [s2i_pkg::CHAR_W-1:0]        ch,
    input  wire s2i_pkg::state_t                   state_in,
    input  wire logic [CNT_W-1:0]                  cnt_in,
    output s2i_pkg::state_t                        state_out,
    output logic [CNT_W-1:0]                       cnt_out,
    output logic                                   emit,
    output s2i_pkg::result_t                       result
);
    import s2i_pkg::*;

    localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(COUNT_MAX);

    state_t              eff;
    state_t              dec;
    logic [CNT_W-1:0]    eff_cnt;
    logic [CNT_W-1:0]    cnt_inc;
    logic [DIGIT_W-1:0]  digit;
    logic [BASE_W-1:0]   rd;
    logic                count_it;
    logic                pre;
    logic                go_digit;
    logic [PROD_W-1:0]   prod;
    logic                neg_ovf;
    logic [CNT_W+OFFSET_W-1:0] cnt_ext;

    // A start item clears the state and samples the requested base.
    always_comb
    begin
        if (start_req)
        begin
            eff.phase    = PH_SPACE;
            eff.radix    = base_req;
            eff.negative = 1'b0;
            eff.acc      = '0;
            eff.ovf      = 1'b0;
            eff_cnt      = '0;
        end
        else
        begin
            eff     = state_in;
            eff_cnt = cnt_in;
        end
    end

    assign digit   = digit_of(ch);
    assign cnt_inc = (eff_cnt < CNT_LIMIT) ? eff_cnt + 1'b1 : eff_cnt;

    // Phase decode; the sign phase falls through into the prefix check.
    always_comb
    begin
        dec      = eff;
        count_it = 1'b0;
        pre      = 1'b0;
        go_digit = 1'b0;
        rd       = eff.radix;
        case (eff.phase)
            PH_SPACE:
            begin
                if (is_space(ch))
                    count_it = 1'b1;
                else if ((ch == CH_PLUS) || (ch == CH_MINUS))
                begin
                    count_it     = 1'b1;
                    dec.negative = (ch == CH_MINUS);
                    dec.phase    = PH_PREFIX;
                end
                else
                    pre = 1'b1;
            end
            PH_PREFIX:
                pre = 1'b1;
            PH_ZERO:
            begin
                if ((ch == CH_LO_X) || (ch == CH_UP_X))
                begin
                    count_it  = 1'b1;
                    dec.radix = RADIX_HEX;
                    dec.phase = PH_DIGITS;
                end
                else
                begin
                    // The leading zero was a digit; auto base becomes octal.
                    rd       = (eff.radix == RADIX_AUTO) ? RADIX_OCT : eff.radix;
                    go_digit = 1'b1;
                end
            end
            PH_DIGITS:
                go_digit = 1'b1;
            default:
            begin
                dec = eff;
            end
        endcase

        // Prefix check: a zero may open a hex prefix in auto or hex base.
        if (pre)
        begin
            if ((ch == CH_ZERO) && ((eff.radix == RADIX_AUTO) || (eff.radix == RADIX_HEX)))
            begin
                count_it  = 1'b1;
                dec.phase = PH_ZERO;
            end
            else
            begin
                rd       = (eff.radix == RADIX_AUTO) ? RADIX_DEC : eff.radix;
                go_digit = 1'b1;
            end
        end
    end

    // Multiply-add of the accumulator; the full product shows any overflow.
    assign prod    = PROD_W'(eff.acc) * PROD_W'(rd) + PROD_W'(digit[BASE_W-1:0]);
    assign neg_ovf = eff.negative && (eff.acc == SMIN);

    // Digit step: accumulate, or end the conversion on a non-digit.
    always_comb
    begin
        state_out = dec;
        emit      = 1'b0;
        if (go_digit)
        begin
            state_out.radix = rd;
            state_out.phase = PH_DIGITS;
            if (digit >= DIGIT_W'(rd))
            begin
                emit            = 1'b1;
                state_out.ovf   = eff.ovf || neg_ovf;
                state_out.phase = PH_DONE;
            end
            else
            begin
                state_out.acc = prod[VALUE_W-1:0];
                if (prod[PROD_W-1:VALUE_W-1] != '0)
                    state_out.ovf = 1'b1;
            end
        end
    end

    assign cnt_out = (count_it || (go_digit && !emit)) ? cnt_inc : eff_cnt;

    // Result fields, meaningful on the terminating item.
    assign cnt_ext           = {{OFFSET_W{1'b0}}, eff_cnt};
    assign result.value      = eff.negative ? (VALUE_W'(0) - eff.acc) : eff.acc;
    assign result.end_offset = cnt_ext[OFFSET_W-1:0];
    assign result.ovf        = eff.ovf || neg_ovf;

endmodule

`default_nettype wire

// ===== design/s2i_checker.sv =====
// Port-level checks for the string-to-integer parser, bound to the top level.
// Depends on s2i_pkg and string_to_integer_parser.
`default_nettype none

module s2i_checker (
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           s_tready,
    input wire logic                           m_tvalid,
    input wire logic                           m_tready,
    input wire logic [s2i_pkg::M_TDATA_W-1:0]  m_tdata
);
    import s2i_pkg::*;

    // A result that is not taken stays put.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result item changed while stalled");

    // The input side only backs up behind a stalled result.
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without a stalled result");

    // Reset leaves both stages empty.
    a_reset_empty: assert property (@(posedge clk)
        !rst_n |=> !m_tvalid && s_tready)
        else $error("pipeline not empty after reset");

    // Padding bits of the result item are always zero.
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[M_TDATA_W-1:VALUE_W+OFFSET_W+1] == '0)
        else $error("result padding not zero");

endmodule

bind string_to_integer_parser s2i_checker u_s2i_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
